// File: src/dashed_circle_rasterizer_unit_macros.svh
// assertion macros used by the rasterizer checker
`ifndef DASHED_CIRCLE_RASTERIZER_UNIT_MACROS_SVH
`define DASHED_CIRCLE_RASTERIZER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dcr_pkg.sv
// shared types and constants for the dashed circle rasterizer
package dcr_pkg;

    localparam int CENTER_BITS = 12;
    localparam int RADIUS_BITS = 6;
    localparam int COLOR_BITS  = 24;
    localparam int RUN_BITS    = 4;
    localparam int OUT_BITS    = 14;
    localparam int OFFSET_BITS = 7;
    localparam int ERR_BITS    = 9;
    localparam int RESULT_CAP  = 46;
    localparam int STEP_BITS   = 6;
    localparam int APB_ADDR_BITS = 2;
    localparam int APB_DATA_BITS = 32;

    // register byte addresses
    localparam logic [APB_ADDR_BITS-1:0] ADDR_DASH_RUN = 2'd0;

    localparam logic [RUN_BITS-1:0] DASH_RUN_RESET = 4'd1;

    // classified circle command, as held in the queue
    typedef struct packed {
        logic [CENTER_BITS-1:0] cx;
        logic [CENTER_BITS-1:0] cy;
        logic [RADIUS_BITS-1:0] radius;
        logic [COLOR_BITS-1:0]  color;
        logic                   dashed;
        logic [RUN_BITS-1:0]    run;
    } dcr_cmd_t;

    // queue status: full is seen by the front, empty by the back
    typedef struct packed {
        logic full;
        logic empty;
    } dcr_q_status_t;

endpackage

// File: src/dashed_circle_rasterizer_unit.sv
// top level of the dashed midpoint circle rasterizer
//
//   channel   direction   handshake             payload
//   in        to block    in_valid / in_stall   center_x center_y radius color dashed
//   out       from block  out_valid / out_stall eight coordinates, pixel_color,
//                                               draw_enable, last_step
//   cfg       to block    apb psel/penable      dash_run_length at byte address 0
//
// a circle of radius r gives about r/sqrt(2)+1 results (at most 46), one per cycle
// from the back's recurrence register while out is not stalled, once loaded from the queue.
// the front register and two-entry queue let up to three commands wait while a circle runs.
// reset clears handshake and sequencer state and sets dash_run_length to 1.
// a stall on out holds the result register and pauses the recurrence.
module dashed_circle_rasterizer_unit #(
    parameter int MAX_RADIUS = 63,
    parameter int COORD_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dcr_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [dcr_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [dcr_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [dcr_pkg::CENTER_BITS-1:0]      center_x,
    input  logic [dcr_pkg::CENTER_BITS-1:0]      center_y,
    input  logic [dcr_pkg::RADIUS_BITS-1:0]      radius,
    input  logic [dcr_pkg::COLOR_BITS-1:0]       color,
    input  logic                                 dashed,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [dcr_pkg::OUT_BITS-1:0]  x_plus_major,
    output logic signed [dcr_pkg::OUT_BITS-1:0]  x_minus_major,
    output logic signed [dcr_pkg::OUT_BITS-1:0]  y_plus_minor,
    output logic signed [dcr_pkg::OUT_BITS-1:0]  y_minus_minor,
    output logic signed [dcr_pkg::OUT_BITS-1:0]  x_plus_minor,
    output logic signed [dcr_pkg::OUT_BITS-1:0]  x_minus_minor,
    output logic signed [dcr_pkg::OUT_BITS-1:0]  y_plus_major,
    output logic signed [dcr_pkg::OUT_BITS-1:0]  y_minus_major,
    output logic [dcr_pkg::COLOR_BITS-1:0]       pixel_color,
    output logic                                 draw_enable,
    output logic                                 last_step
);
    import dcr_pkg::*;

    logic [RUN_BITS-1:0] dash_run_reg;
    logic [RUN_BITS-1:0] dash_run_next;
    logic                cfg_write;
    logic                push;
    logic                pop;
    dcr_cmd_t            push_cmd;
    dcr_cmd_t            pop_cmd;
    dcr_q_status_t       q_status;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_DASH_RUN);
    assign dash_run_next = cfg_write ? pwdata[RUN_BITS-1:0] : dash_run_reg;
    assign prdata = (paddr == ADDR_DASH_RUN) ? APB_DATA_BITS'(dash_run_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_run_reg <= DASH_RUN_RESET;
        end
        else
        begin
            dash_run_reg <= dash_run_next;
        end
    end

    dcr_front #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .center_x        (center_x),
        .center_y        (center_y),
        .radius          (radius),
        .color           (color),
        .dashed          (dashed),
        .dash_run_length (dash_run_reg),
        .q_status        (q_status),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    dcr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    dcr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .pop_cmd       (pop_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .x_plus_major  (x_plus_major),
        .x_minus_major (x_minus_major),
        .y_plus_minor  (y_plus_minor),
        .y_minus_minor (y_minus_minor),
        .x_plus_minor  (x_plus_minor),
        .x_minus_minor (x_minus_minor),
        .y_plus_major  (y_plus_major),
        .y_minus_major (y_minus_major),
        .pixel_color   (pixel_color),
        .draw_enable   (draw_enable),
        .last_step     (last_step)
    );

endmodule

// File: src/dcr_front.sv
// front: accepts circle commands, saturates radius, masks centers, resolves run length
module dcr_front #(
    parameter int MAX_RADIUS = 63,
    parameter int COORD_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dcr_pkg::CENTER_BITS-1:0] center_x,
    input  logic [dcr_pkg::CENTER_BITS-1:0] center_y,
    input  logic [dcr_pkg::RADIUS_BITS-1:0] radius,
    input  logic [dcr_pkg::COLOR_BITS-1:0]  color,
    input  logic                            dashed,
    input  logic [dcr_pkg::RUN_BITS-1:0]    dash_run_length,
    input  dcr_pkg::dcr_q_status_t          q_status,
    output logic                            push,
    output dcr_pkg::dcr_cmd_t               push_cmd
);
    import dcr_pkg::*;

    localparam int CB = (COORD_BITS >= CENTER_BITS) ? CENTER_BITS : COORD_BITS;
    localparam logic [CENTER_BITS-1:0] CMASK = CENTER_BITS'((33'd1 << CB) - 33'd1);
    localparam logic [10:0] MAX_R = 11'(MAX_RADIUS);

    logic      front_valid_reg;
    logic      front_valid_next;
    dcr_cmd_t  cmd_reg;
    dcr_cmd_t  cmd_next;
    logic      accept;

    // handshake
    assign push     = front_valid_reg && !q_status.full;
    assign in_stall = front_valid_reg && q_status.full;
    assign accept   = in_valid && !in_stall;
    assign push_cmd = cmd_reg;

    // classification of the incoming command
    always_comb
    begin
        cmd_next.cx     = center_x & CMASK;
        cmd_next.cy     = center_y & CMASK;
        cmd_next.radius = ({5'd0, radius} > MAX_R) ? RADIUS_BITS'(MAX_R) : radius;
        cmd_next.color  = color;
        cmd_next.dashed = dashed;
        cmd_next.run    = (dash_run_length == '0) ? RUN_BITS'(1) : dash_run_length;
    end

    assign front_valid_next = accept || (front_valid_reg && !push);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// File: src/dcr_queue.sv
// two-entry command queue between front and back
module dcr_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  dcr_pkg::dcr_cmd_t      push_cmd,
    input  logic                   pop,
    output dcr_pkg::dcr_cmd_t      pop_cmd,
    output dcr_pkg::dcr_q_status_t status
);
    import dcr_pkg::*;

    dcr_cmd_t    entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/dcr_back.sv
// back: runs the midpoint octant recurrence and drives the result register
module dcr_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dcr_pkg::dcr_q_status_t             q_status,
    input  dcr_pkg::dcr_cmd_t                   pop_cmd,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [dcr_pkg::OUT_BITS-1:0] x_plus_major,
    output logic signed [dcr_pkg::OUT_BITS-1:0] x_minus_major,
    output logic signed [dcr_pkg::OUT_BITS-1:0] y_plus_minor,
    output logic signed [dcr_pkg::OUT_BITS-1:0] y_minus_minor,
    output logic signed [dcr_pkg::OUT_BITS-1:0] x_plus_minor,
    output logic signed [dcr_pkg::OUT_BITS-1:0] x_minus_minor,
    output logic signed [dcr_pkg::OUT_BITS-1:0] y_plus_major,
    output logic signed [dcr_pkg::OUT_BITS-1:0] y_minus_major,
    output logic [dcr_pkg::COLOR_BITS-1:0]     pixel_color,
    output logic                                draw_enable,
    output logic                                last_step
);
    import dcr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } back_state_t;

    back_state_t                state_reg;
    back_state_t                state_next;
    dcr_cmd_t                   cmd_reg;
    logic [OFFSET_BITS-1:0]     major_reg;
    logic [OFFSET_BITS-1:0]     major_next;
    logic [OFFSET_BITS-1:0]     minor_reg;
    logic [OFFSET_BITS-1:0]     minor_next;
    logic signed [ERR_BITS-1:0] err_reg;
    logic signed [ERR_BITS-1:0] err_next;
    logic [RUN_BITS-1:0]        dash_count_reg;
    logic [RUN_BITS-1:0]        dash_count_next;
    logic                       dash_on_reg;
    logic                       dash_on_next;
    logic [STEP_BITS-1:0]       step_reg;
    logic [STEP_BITS-1:0]       step_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       load;
    logic                       emit;
    logic                       last;
    logic signed [ERR_BITS:0]   err_acc;
    logic [RUN_BITS-1:0]        dash_inc;
    logic [OUT_BITS-1:0]        cx_w;
    logic [OUT_BITS-1:0]        cy_w;
    logic [OUT_BITS-1:0]        mj_w;
    logic [OUT_BITS-1:0]        mn_w;

    assign load = (state_reg == ST_IDLE) && !q_status.empty;
    assign pop  = load;
    assign emit = (state_reg == ST_RUN) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;

    // one recurrence step
    always_comb
    begin
        err_acc    = (ERR_BITS+1)'(err_reg) + (ERR_BITS+1)'({minor_reg, 1'b1});
        minor_next = minor_reg + OFFSET_BITS'(1);
        major_next = major_reg;
        err_next   = ERR_BITS'(err_acc);
        if (err_acc >= 0)
        begin
            major_next = major_reg - OFFSET_BITS'(1);
            err_next   = ERR_BITS'(err_acc - (ERR_BITS+1)'({major_next, 1'b0}));
        end
        dash_inc        = dash_count_reg + RUN_BITS'(1);
        dash_count_next = dash_count_reg;
        dash_on_next    = dash_on_reg;
        if (cmd_reg.dashed)
        begin
            dash_count_next = dash_inc;
            if (dash_inc == cmd_reg.run)
            begin
                dash_count_next = '0;
                dash_on_next    = !dash_on_reg;
            end
        end
        step_next = step_reg + STEP_BITS'(1);
        // major drops below zero on a zero radius, so compare signed
        last = ($signed(minor_next) > $signed(major_next))
            || (step_reg == STEP_BITS'(RESULT_CAP - 1));
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (emit && last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // recurrence state
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg        <= pop_cmd;
            major_reg      <= OFFSET_BITS'(pop_cmd.radius);
            minor_reg      <= '0;
            err_reg        <= -ERR_BITS'(pop_cmd.radius);
            dash_count_reg <= '0;
            dash_on_reg    <= 1'b1;
            step_reg       <= '0;
        end
        else if (emit)
        begin
            major_reg      <= major_next;
            minor_reg      <= minor_next;
            err_reg        <= err_next;
            dash_count_reg <= dash_count_next;
            dash_on_reg    <= dash_on_next;
            step_reg       <= step_next;
        end
    end

    // mirrored coordinates of the current step
    assign cx_w = OUT_BITS'(cmd_reg.cx);
    assign cy_w = OUT_BITS'(cmd_reg.cy);
    assign mj_w = OUT_BITS'(major_reg);
    assign mn_w = OUT_BITS'(minor_reg);

    // result register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            x_plus_major  <= cx_w + mj_w;
            x_minus_major <= cx_w - mj_w;
            y_plus_minor  <= cy_w + mn_w;
            y_minus_minor <= cy_w - mn_w;
            x_plus_minor  <= cx_w + mn_w;
            x_minus_minor <= cx_w - mn_w;
            y_plus_major  <= cy_w + mj_w;
            y_minus_major <= cy_w - mj_w;
            pixel_color   <= cmd_reg.color;
            draw_enable   <= dash_on_reg;
            last_step     <= last;
        end
    end

endmodule

// File: src/dcr_checker.sv
// port-level checker for the rasterizer and its bind
`include "dashed_circle_rasterizer_unit_macros.svh"

module dcr_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [dcr_pkg::OUT_BITS-1:0] x_plus_major,
    input logic signed [dcr_pkg::OUT_BITS-1:0] x_minus_major,
    input logic signed [dcr_pkg::OUT_BITS-1:0] x_plus_minor,
    input logic signed [dcr_pkg::OUT_BITS-1:0] x_minus_minor,
    input logic signed [dcr_pkg::OUT_BITS-1:0] y_plus_major,
    input logic signed [dcr_pkg::OUT_BITS-1:0] y_minus_major
);
    import dcr_pkg::*;

    logic [OUT_BITS-1:0] x_major_span;
    logic [OUT_BITS-1:0] x_minor_span;
    logic [OUT_BITS-1:0] y_major_span;
    logic [OUT_BITS-1:0] x_major_sum;
    logic [OUT_BITS-1:0] x_minor_sum;

    assign x_major_span = $unsigned(x_plus_major) - $unsigned(x_minus_major);
    assign x_minor_span = $unsigned(x_plus_minor) - $unsigned(x_minus_minor);
    assign y_major_span = $unsigned(y_plus_major) - $unsigned(y_minus_major);
    assign x_major_sum  = $unsigned(x_plus_major) + $unsigned(x_minus_major);
    assign x_minor_sum  = $unsigned(x_plus_minor) + $unsigned(x_minus_minor);

    // a stalled result holds
    `DCR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(x_plus_major), "result changed while stalled")

    // both x pairs mirror about the same center
    `DCR_ASSERT_NOW(a_x_center, out_valid, x_major_sum == x_minor_sum, "x pairs not centered alike")

    // major offset is the same along x and y
    `DCR_ASSERT_NOW(a_major_span, out_valid, x_major_span == y_major_span, "major offset differs in x and y")

    // results stay within one octant
    `DCR_ASSERT_NOW(a_octant, out_valid, x_minor_span <= x_major_span, "minor offset above major offset")

endmodule

bind dashed_circle_rasterizer_unit dcr_checker u_dcr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .x_plus_major  (x_plus_major),
    .x_minus_major (x_minus_major),
    .x_plus_minor  (x_plus_minor),
    .x_minus_minor (x_minus_minor),
    .y_plus_major  (y_plus_major),
    .y_minus_major (y_minus_major)
);
